>>> design/ecb_pkg.sv
`default_nettype none
//------------------------------------------------------------------------------
// ecb_pkg
// Shared types, constants and curve codes for the easing curve channel bank.
//------------------------------------------------------------------------------
package ecb_pkg;
    localparam int CHANNELS  = 32;
    localparam int CH_W      = 5;
    localparam int POS_W     = 22;
    localparam int VAL_W     = 19;
    localparam int SPD_W     = 17;

    localparam logic [2:0] KIND_BEZIER  = 3'd0;
    localparam logic [2:0] KIND_EL_IN   = 3'd1;
    localparam logic [2:0] KIND_EL_OUT  = 3'd2;
    localparam logic [2:0] KIND_EL_IO   = 3'd3;
    localparam logic [2:0] KIND_BN_IN   = 3'd4;
    localparam logic [2:0] KIND_BN_OUT  = 3'd5;
    localparam logic [2:0] KIND_BN_IO   = 3'd6;
    localparam logic [2:0] KIND_NONE    = 3'd7;

    localparam logic CMD_ADVANCE = 1'b0;
    localparam logic CMD_RESET   = 1'b1;
endpackage
`default_nettype wire

>>> design/easing_curve_channel_bank_top.sv
`default_nettype none
//------------------------------------------------------------------------------
// easing_curve_channel_bank_top
// Bank of 32 animation channels evaluating Bezier, elastic and bounce curves.
//------------------------------------------------------------------------------
// Channel   | Handshake          | Fields
// command   | start / busy       | command, channel, curve_kind, speed, ctrl_*
// result    | done (one cycle)   | out_channel, position, value_x, value_y, wrapped
//
// An item is taken when start is high and busy is low. A sequencer then drives
// one shared 32x32 multiplier through the curve evaluation. Each 64-bit product
// is built from three partial products followed by a hand-back. A reset item
// or the unused curve goes from setup straight to the result; the elastic
// endpoints leave the program at its first step. done and the result are
// registered as busy falls, so busy is already low while done is high and the
// next item can be taken at the edge that ends that cycle.
// Reset clears the channel store valid bits, so every channel reads as zero.
// The result is shown for one cycle with done; the receiver cannot stall it.
//------------------------------------------------------------------------------
module easing_curve_channel_bank_top
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    output      logic                     busy,
    input  wire logic                     command,
    input  wire logic [4:0]               channel,
    input  wire logic [2:0]               curve_kind,
    input  wire logic [16:0]              speed,
    input  wire logic signed [18:0]       ctrl_one_x,
    input  wire logic signed [18:0]       ctrl_one_y,
    input  wire logic signed [18:0]       ctrl_two_x,
    input  wire logic signed [18:0]       ctrl_two_y,
    output      logic                     done,
    output      logic [4:0]               out_channel,
    output      logic [21:0]              position,
    output      logic signed [18:0]       value_x,
    output      logic signed [18:0]       value_y,
    output      logic                     wrapped
);
    import ecb_pkg::*;

    // Sequencer states.
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RD    = 4'd1;
    localparam logic [3:0] S_SETUP = 4'd2;
    localparam logic [3:0] S_RUN   = 4'd3;
    localparam logic [3:0] S_MUL   = 4'd4;
    localparam logic [3:0] S_DONE  = 4'd5;

    // Channel store: valid bits give zero on reset; payload unreset.
    logic [CHANNELS-1:0]    vld_reg;
    logic [POS_W-1:0]       pos_mem [CHANNELS];
    logic signed [VAL_W-1:0] lx_mem [CHANNELS];
    logic signed [VAL_W-1:0] ly_mem [CHANNELS];

    logic [3:0]  state_reg;
    logic        cmd_reg;
    logic [4:0]  ch_reg;
    logic [2:0]  kind_reg;
    logic [16:0] spd_reg;
    logic signed [18:0] p1x_reg, p1y_reg, p2x_reg, p2y_reg;
    logic [POS_W-1:0] old_reg, new_reg;
    logic        wrap_reg;
    logic signed [VAL_W-1:0] lx_reg, ly_reg;
    logic [5:0]  pc_reg;

    // Working registers for the programs.
    logic signed [63:0] a_reg, b_reg, c_reg, d_reg, e_reg, acc_reg;
    logic signed [63:0] ma_reg, mb_reg;
    logic [1:0]  mstep_reg;
    logic signed [63:0] mres_reg;
    logic [5:0]  ret_reg;

    // Shared multiplier: one 32x32 unit; the low 64 bits of a 64x64 signed
    // product come from three partial products.
    logic [31:0] mlo_a, mlo_b, mhi_a, mhi_b;
    logic [31:0] mop_a, mop_b;
    logic [63:0] pp;
    always_comb
    begin
        mlo_a = ma_reg[31:0];
        mlo_b = mb_reg[31:0];
        mhi_a = ma_reg[63:32];
        mhi_b = mb_reg[63:32];
        unique case (mstep_reg)
            2'd0:    begin mop_a = mlo_a; mop_b = mlo_b; end
            2'd1:    begin mop_a = mhi_a; mop_b = mlo_b; end
            2'd2:    begin mop_a = mlo_a; mop_b = mhi_b; end
            default: begin mop_a = 32'd0; mop_b = 32'd0; end
        endcase
        pp = {32'd0, mop_a} * {32'd0, mop_b};
    end

    function automatic logic signed [VAL_W-1:0] sat19(input logic signed [63:0] v);
        if (v < -64'sd262144)
            return -19'sd262144;
        else if (v > 64'sd262143)
            return 19'sd262143;
        else
            return v[VAL_W-1:0];
    endfunction

    // Rounded arithmetic shift, half up.
    function automatic logic signed [63:0] rshr(input logic signed [63:0] v,
                                                input logic [5:0] s);
        logic signed [63:0] a;
        a = v + (64'sd1 <<< (s - 6'd1));
        return a >>> s;
    endfunction

    assign busy = (state_reg != S_IDLE);

    logic [POS_W:0] sum_w;
    logic [16:0]    spdc_w;
    logic [63:0]    lim_w;
    logic           rd_vld;
    always_comb
    begin
        rd_vld = vld_reg[ch_reg];
        spdc_w = (spd_reg > 17'd65536) ? 17'd65536 : spd_reg;
        sum_w  = {1'b0, old_reg} + {6'd0, spdc_w};
        lim_w  = 64'd65536 + 64'd60 * {47'd0, spdc_w};
    end

    // Program step: each pc does adds/shifts, kicks one multiply, or both; the product
    // lands in mres_reg and the program resumes at ret_reg. Values are signed 64-bit.
    logic signed [63:0] t_w;
    always_comb
    begin
        t_w = (new_reg > 22'd65536) ? 64'sd65536 : $signed({42'd0, new_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            vld_reg   <= '0;
            done      <= 1'b0;
            mstep_reg <= 2'd0;
            pc_reg    <= 6'd0;
        end
        else
        begin
            done <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        cmd_reg <= command; ch_reg <= channel; kind_reg <= curve_kind;
                        spd_reg <= speed;
                        p1x_reg <= ctrl_one_x; p1y_reg <= ctrl_one_y;
                        p2x_reg <= ctrl_two_x; p2y_reg <= ctrl_two_y;
                        state_reg <= S_RD;
                    end
                end
                S_RD:
                begin
                    old_reg <= rd_vld ? pos_mem[ch_reg] : '0;
                    lx_reg  <= rd_vld ? lx_mem[ch_reg]  : '0;
                    ly_reg  <= rd_vld ? ly_mem[ch_reg]  : '0;
                    state_reg <= S_SETUP;
                end
                S_SETUP:
                begin
                    wrap_reg <= 1'b0;
                    if (cmd_reg == CMD_RESET)
                    begin
                        new_reg <= '0;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        if ({41'd0, sum_w} > lim_w)
                        begin
                            new_reg <= '0; wrap_reg <= 1'b1;
                        end
                        else if (sum_w[POS_W])
                            new_reg <= '1;
                        else
                            new_reg <= sum_w[POS_W-1:0];
                        pc_reg <= 6'd0;
                        state_reg <= (kind_reg == KIND_NONE) ? S_DONE : S_RUN;
                    end
                end
                S_MUL:
                begin
                    unique case (mstep_reg)
                        2'd0: begin mres_reg <= $signed(pp); mstep_reg <= 2'd1; end
                        2'd1: begin mres_reg <= mres_reg + $signed({pp[31:0], 32'd0});
                                    mstep_reg <= 2'd2; end
                        2'd2: begin mres_reg <= mres_reg + $signed({pp[31:0], 32'd0});
                                    mstep_reg <= 2'd3; end
                        default: begin
                            mstep_reg <= 2'd0;
                            pc_reg <= ret_reg;
                            state_reg <= S_RUN;
                        end
                    endcase
                end
                S_RUN:
                begin
                    if (kind_reg == KIND_BEZIER)
                    begin
                        // a=t, b=u; products through the shared multiplier.
                        unique case (pc_reg)
                            6'd0: begin
                                a_reg <= (old_reg > 22'd65536) ? 64'sd65536
                                         : $signed({42'd0, old_reg});
                                b_reg <= 64'sd65536 - ((old_reg > 22'd65536) ? 64'sd65536
                                         : $signed({42'd0, old_reg}));
                                pc_reg <= 6'd1;
                            end
                            6'd1: begin ma_reg <= a_reg; mb_reg <= b_reg; ret_reg <= 6'd2;
                                        state_reg <= S_MUL; end
                            6'd2: begin c_reg <= (mres_reg + 64'sd32768) >>> 16; // tu
                                        pc_reg <= 6'd3; end
                            6'd3: begin ma_reg <= c_reg * 3; mb_reg <= b_reg; ret_reg <= 6'd4;
                                        state_reg <= S_MUL; end
                            6'd4: begin c_reg <= (mres_reg + 64'sd32768) >>> 16; // w1
                                        ma_reg <= a_reg; mb_reg <= a_reg; ret_reg <= 6'd5;
                                        state_reg <= S_MUL; end
                            6'd5: begin d_reg <= (mres_reg + 64'sd32768) >>> 16; // tt
                                        pc_reg <= 6'd6; end
                            6'd6: begin ma_reg <= d_reg * 3; mb_reg <= b_reg; ret_reg <= 6'd7;
                                        state_reg <= S_MUL; end
                            6'd7: begin e_reg <= (mres_reg + 64'sd32768) >>> 16; // w2
                                        ma_reg <= d_reg; mb_reg <= a_reg; ret_reg <= 6'd8;
                                        state_reg <= S_MUL; end
                            6'd8: begin d_reg <= (mres_reg + 64'sd32768) >>> 16; // w3
                                        ma_reg <= c_reg; mb_reg <= 64'(p1x_reg); ret_reg <= 6'd9;
                                        state_reg <= S_MUL; end
                            6'd9: begin acc_reg <= mres_reg;
                                        ma_reg <= e_reg; mb_reg <= 64'(p2x_reg); ret_reg <= 6'd10;
                                        state_reg <= S_MUL; end
                            6'd10: begin lx_reg <= sat19(rshr(acc_reg + mres_reg, 6'd16) + d_reg);
                                        ma_reg <= c_reg; mb_reg <= 64'(p1y_reg); ret_reg <= 6'd11;
                                        state_reg <= S_MUL; end
                            6'd11: begin acc_reg <= mres_reg;
                                        ma_reg <= e_reg; mb_reg <= 64'(p2y_reg); ret_reg <= 6'd12;
                                        state_reg <= S_MUL; end
                            default: begin
                                ly_reg <= sat19(rshr(acc_reg + mres_reg, 6'd16) + d_reg);
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                    else if (kind_reg >= KIND_BN_IN)
                    begin
                        // Bounce: a = argument of bounce_out, then square, divide.
                        unique case (pc_reg)
                            6'd0: begin
                                if (kind_reg == KIND_BN_IN)      a_reg <= 64'sd65536 - t_w;
                                else if (kind_reg == KIND_BN_OUT) a_reg <= t_w;
                                else if (2 * t_w < 64'sd65536)   a_reg <= 64'sd65536 - 2 * t_w;
                                else                             a_reg <= 2 * t_w - 64'sd65536;
                                pc_reg <= 6'd1;
                            end
                            6'd1: begin
                                b_reg <= 11 * a_reg;
                                pc_reg <= 6'd2;
                            end
                            6'd2: begin
                                // c=d, e=den shift, d=base
                                priority if (b_reg < 64'sd262144)
                                begin c_reg <= b_reg; e_reg <= 64'sd20; d_reg <= 64'sd0; end
                                else if (b_reg < 64'sd524288)
                                begin c_reg <= b_reg - 64'sd393216; e_reg <= 64'sd20;
                                      d_reg <= 64'sd49152; end
                                else if (b_reg < 64'sd655360)
                                begin c_reg <= b_reg - 64'sd589824; e_reg <= 64'sd20;
                                      d_reg <= 64'sd61440; end
                                else
                                begin
                                    c_reg <= (22 * a_reg - 64'sd1376256 < 0)
                                             ? 64'sd1376256 - 22 * a_reg
                                             : 22 * a_reg - 64'sd1376256;
                                    e_reg <= 64'sd22; d_reg <= 64'sd64512;
                                end
                                pc_reg <= 6'd3;
                            end
                            6'd3: begin ma_reg <= c_reg; mb_reg <= c_reg; ret_reg <= 6'd4;
                                        state_reg <= S_MUL; end
                            6'd4: begin
                                acc_reg <= ((mres_reg + (64'sd1 <<< (e_reg[5:0] - 6'd1)))
                                            >>> e_reg[5:0]) + d_reg;
                                pc_reg <= 6'd5;
                            end
                            default: begin
                                if (kind_reg == KIND_BN_IN)
                                    ly_reg <= sat19(64'sd65536 - acc_reg);
                                else if (kind_reg == KIND_BN_OUT)
                                    ly_reg <= sat19(acc_reg);
                                else if (2 * t_w < 64'sd65536)
                                    ly_reg <= sat19((64'sd65536 - acc_reg + 1) >>> 1);
                                else
                                    ly_reg <= sat19((64'sd65536 + acc_reg + 1) >>> 1);
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                    else
                    begin
                        // Elastic: pow2 in a, sine in b, polynomial through mul.
                        unique case (pc_reg)
                            6'd0: begin
                                if (t_w == 0)
                                begin ly_reg <= '0; state_reg <= S_DONE; end
                                else if (t_w == 64'sd65536)
                                begin ly_reg <= 19'sd65536; state_reg <= S_DONE; end
                                else
                                begin
                                    // c = exponent e, d = phase numerator n*mul*256
                                    // e = divisor div*ONE
                                    unique case (kind_reg)
                                        KIND_EL_IN: begin
                                            c_reg <= 10 * t_w - 64'sd655360;
                                            d_reg <= (10 * t_w - 64'sd704512) * 256;
                                            e_reg <= 64'sd196608;
                                        end
                                        KIND_EL_OUT: begin
                                            c_reg <= -10 * t_w;
                                            d_reg <= (10 * t_w - 64'sd49152) * 256;
                                            e_reg <= 64'sd196608;
                                        end
                                        default: begin
                                            c_reg <= (2 * t_w < 64'sd65536)
                                                     ? 20 * t_w - 64'sd655360
                                                     : 64'sd655360 - 20 * t_w;
                                            d_reg <= (20 * t_w - 64'sd729088) * 512;
                                            e_reg <= 64'sd589824;
                                        end
                                    endcase
                                    pc_reg <= 6'd1;
                                    acc_reg <= 64'sd0;
                                end
                            end
                            // Floor divide d by e by restoring over 64 steps is
                            // long; the divisor is 3*2^16 or 9*2^16, so divide
                            // by 2^16 with floor then by 3 or 9 via reciprocal.
                            6'd1: begin
                                d_reg <= d_reg >>> 16;
                                pc_reg <= 6'd2;
                            end
                            6'd2: begin
                                // floor(d/k): reciprocal multiply on a small positive
                                // bias, a multiple of 256 so the phase index keeps.
                                a_reg <= d_reg + 64'sd65536 * ((e_reg == 64'sd196608) ? 3 : 9);
                                ma_reg <= d_reg + 64'sd65536 *
                                          ((e_reg == 64'sd196608) ? 3 : 9);
                                mb_reg <= (e_reg == 64'sd196608) ? 64'sd1431655766
                                                                 : 64'sd477218589;
                                ret_reg <= 6'd3;
                                state_reg <= S_MUL;
                            end
                            6'd3: begin
                                b_reg <= mres_reg >>> 32;
                                pc_reg <= 6'd4;
                            end
                            6'd4: begin
                                // correct the reciprocal estimate
                                if (b_reg * ((e_reg == 64'sd196608) ? 3 : 9) > a_reg)
                                    b_reg <= b_reg - 1;
                                else if ((b_reg + 1) * ((e_reg == 64'sd196608) ? 3 : 9)
                                         <= a_reg)
                                    b_reg <= b_reg + 1;
                                pc_reg <= 6'd5;
                            end
                            6'd5: begin
                                // index mod 256, quadrant, z in Q30
                                a_reg <= {56'd0, b_reg[7:0]};
                                pc_reg <= 6'd6;
                            end
                            6'd6: begin
                                // quad = idx[7:6], rem = idx[5:0]*4, z = rem<<30/256
                                d_reg <= {62'd0, a_reg[7:6]};
                                b_reg <= a_reg[6] ? (64'sd1073741824 - ({58'd0, a_reg[5:0]} <<< 24))
                                                  : ({58'd0, a_reg[5:0]} <<< 24);
                                pc_reg <= 6'd7;
                            end
                            6'd7: begin ma_reg <= b_reg; mb_reg <= b_reg; ret_reg <= 6'd8;
                                        state_reg <= S_MUL; end
                            6'd8: begin a_reg <= mres_reg >>> 30; // z2
                                        acc_reg <= 64'sd172271; pc_reg <= 6'd9; end
                            6'd9, 6'd11, 6'd13, 6'd15: begin
                                ma_reg <= acc_reg; mb_reg <= a_reg; ret_reg <= pc_reg + 6'd1;
                                state_reg <= S_MUL;
                            end
                            6'd10: begin acc_reg <= 64'sd5026995 - (mres_reg >>> 30);
                                         pc_reg <= 6'd11; end
                            6'd12: begin acc_reg <= 64'sd85569305 - (mres_reg >>> 30);
                                         pc_reg <= 6'd13; end
                            6'd14: begin acc_reg <= 64'sd693598669 - (mres_reg >>> 30);
                                         pc_reg <= 6'd15; end
                            6'd16: begin acc_reg <= 64'sd1686629713 - (mres_reg >>> 30);
                                         pc_reg <= 6'd17; end
                            6'd17: begin ma_reg <= acc_reg; mb_reg <= b_reg; ret_reg <= 6'd18;
                                         state_reg <= S_MUL; end
                            6'd18: begin
                                b_reg <= d_reg[1] ? -(mres_reg >>> 30) : (mres_reg >>> 30);
                                // pow2: ip = floor(c/2^16), f = low 16 bits << 14
                                d_reg <= c_reg >>> 16;
                                a_reg <= {48'd0, c_reg[15:0]} <<< 14;
                                acc_reg <= 64'sd11942376;
                                pc_reg <= 6'd19;
                            end
                            6'd19, 6'd21, 6'd23, 6'd25: begin
                                ma_reg <= acc_reg; mb_reg <= a_reg; ret_reg <= pc_reg + 6'd1;
                                state_reg <= S_MUL;
                            end
                            6'd20: begin acc_reg <= 64'sd59597083 + (mres_reg >>> 30);
                                         pc_reg <= 6'd21; end
                            6'd22: begin acc_reg <= 64'sd257941247 + (mres_reg >>> 30);
                                         pc_reg <= 6'd23; end
                            6'd24: begin acc_reg <= 64'sd744261118 + (mres_reg >>> 30);
                                         pc_reg <= 6'd25; end
                            6'd26: begin
                                acc_reg <= (64'sd1073741824 + (mres_reg >>> 30))
                                           >>> (-d_reg[5:0]);
                                pc_reg <= 6'd27;
                            end
                            6'd27: begin ma_reg <= acc_reg; mb_reg <= b_reg; ret_reg <= 6'd28;
                                         state_reg <= S_MUL; end
                            default: begin
                                unique case (kind_reg)
                                    KIND_EL_IN: ly_reg <= sat19(-rshr(mres_reg, 6'd44));
                                    KIND_EL_OUT: ly_reg <= sat19(rshr(mres_reg, 6'd44)
                                                                 + 64'sd65536);
                                    default:
                                        if (2 * t_w < 64'sd65536)
                                            ly_reg <= sat19(-rshr(mres_reg, 6'd45));
                                        else
                                            ly_reg <= sat19(rshr(mres_reg, 6'd45)
                                                            + 64'sd65536);
                                endcase
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end
                default:
                begin
                    pos_mem[ch_reg] <= new_reg;
                    lx_mem[ch_reg]  <= lx_reg;
                    ly_mem[ch_reg]  <= ly_reg;
                    vld_reg[ch_reg] <= 1'b1;
                    done        <= 1'b1;
                    out_channel <= ch_reg;
                    position    <= new_reg;
                    value_x     <= lx_reg;
                    value_y     <= ly_reg;
                    wrapped     <= wrap_reg;
                    state_reg   <= S_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

>>> design/ecb_checker.sv
`default_nettype none
//------------------------------------------------------------------------------
// ecb_checker
// Port-level checks on the easing curve channel bank.
//------------------------------------------------------------------------------
module ecb_checker
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       done,
    input wire logic       wrapped,
    input wire logic [21:0] position
);
    // An accepted item makes the block busy on the next cycle.
    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy) else $error("item not taken");
    // A result strobe lasts a single cycle.
    a_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done held");
    // A wrap always leaves the position at zero.
    a_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        done && wrapped |-> position == 22'd0) else $error("wrap not zero");
    // The strobe comes when the block goes idle.
    a_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("done while busy");
endmodule

bind easing_curve_channel_bank_top ecb_checker u_ecb_checker
(
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .done(done), .wrapped(wrapped), .position(position)
);
`default_nettype wire
